// File: rtl/rfa_pkg.sv
`default_nettype none
package rfa_pkg;

    localparam int OP_W = 3;
    localparam int NUM_W = 64;
    localparam int DEN_W = 62;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_CMP = 3'd4,
        OP_RED = 3'd5
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ZERODEN = 2'd1,
        ST_DIVZERO = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ORD_EQ     = 2'd0,
        ORD_FIRST  = 2'd1,
        ORD_SECOND = 2'd2
    } order_t;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [31:0] first_numerator;
        logic signed [31:0] first_denominator;
        logic signed [31:0] second_numerator;
        logic signed [31:0] second_denominator;
    } in_item_t;

    typedef struct packed {
        logic signed [63:0] result_numerator;
        logic [61:0]        result_denominator;
        logic [1:0]         order_result;
        logic [1:0]         status;
    } out_item_t;

endpackage
`default_nettype wire

// File: rtl/rational_fraction_alu.sv
`default_nettype none
// Rational fraction ALU. Takes a/b, c/d and an opcode (add, subtract,
// multiply, divide, compare, reduce) and returns one fraction, unreduced for
// all but reduce, a compare outcome and a status (zero denominator, division
// by zero). Denominators are first made positive, their sign moved to the
// numerator. Each transaction is handled alone: s_ready is high only while
// the block is idle. Add/subtract/multiply/divide/compare go from accept back
// to idle through three product steps, one finish step and an output state
// held until m_ready is high, all products going through one shared
// multiplier, one product per cycle. Reduce with a nonzero denominator leaves
// the first product step for an iterative binary gcd that strips common
// factors of two, then halves and subtracts, the number of steps set by the
// bit lengths of both magnitudes. It then divides both magnitudes by the gcd,
// one quotient bit per cycle. A finished result waits in an output register
// until m_ready takes it.
module rational_fraction_alu #(
    parameter int OPERAND_WIDTH = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire rfa_pkg::in_item_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output rfa_pkg::out_item_t     m_data
);
    import rfa_pkg::*;

    localparam int W = OPERAND_WIDTH + 1;   // room for the negated minimum
    localparam int P = 2 * W;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_M1   = 7'b0000010,
        S_M2   = 7'b0000100,
        S_M3   = 7'b0001000,
        S_FIN  = 7'b0010000,
        S_GCD  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t             state_reg, state_next;
    logic [2:0]         op_reg;
    logic signed [W-1:0] a_reg, b_reg, c_reg, d_reg;
    logic signed [P-1:0] p1_reg, p2_reg;
    logic signed [W-1:0] ma, mb;
    logic               mul_go, gcd_go, gcd_done;
    logic signed [P-1:0] prod;
    logic [W-1:0]       qx, qy, amag;
    out_item_t          res_reg;
    logic               mvalid_reg;

    // operands sign extended from OPERAND_WIDTH; denominators are normalized when registered
    logic signed [W-1:0] ia, ib, ic, id;
    always_comb begin
        ia = W'(signed'(s_data.first_numerator[OPERAND_WIDTH-1:0]));
        ib = W'(signed'(s_data.first_denominator[OPERAND_WIDTH-1:0]));
        ic = W'(signed'(s_data.second_numerator[OPERAND_WIDTH-1:0]));
        id = W'(signed'(s_data.second_denominator[OPERAND_WIDTH-1:0]));
    end

    assign amag = a_reg[W-1] ? W'(-a_reg) : W'(a_reg);

    // multiplier operand select per sequencer step; each product is registered and lands in the next cycle
    always_comb begin
        ma = a_reg; mb = d_reg;
        case (state_reg)
            S_M1: begin ma = a_reg; mb = (op_reg == OP_MUL) ? c_reg : d_reg; end
            S_M2: begin ma = b_reg; mb = (op_reg == OP_DIV) ? c_reg : d_reg; end
            S_M3: begin ma = c_reg; mb = b_reg; end
            default: ;
        endcase
    end
    assign mul_go = (state_reg == S_M1) || (state_reg == S_M2) || (state_reg == S_M3);

    rfa_mul #(.W(W)) u_mul (
        .aclk(aclk), .start(mul_go),
        .op_a(ma), .op_b(mb), .prod(prod)
    );

    assign gcd_go = (state_reg == S_GCD);
    rfa_divgcd #(.W(W)) u_gcd (
        .aclk(aclk), .aresetn(aresetn), .start(gcd_go),
        .x_in(amag), .y_in(W'(b_reg)), .qx(qx), .qy(qy), .done(gcd_done)
    );

    logic gcd_started_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (s_valid) state_next = S_M1;
            // reduce with a nonzero denominator branches from the first product step into the gcd unit
            S_M1: begin
                if (op_reg == 3'(OP_RED) && b_reg != '0)
                    state_next = S_GCD;
                else
                    state_next = S_M2;
            end
            S_M2:   state_next = S_M3;
            S_M3:   state_next = S_FIN;
            S_FIN:  state_next = S_OUT;
            S_GCD:  if (gcd_done) state_next = S_OUT;
            S_OUT:  if (m_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    logic signed [P-1:0] p3;
    assign p3 = prod;   // third product lands while in S_FIN

    logic [63:0] num, den;
    logic [1:0]  ord, st;
    logic signed [P-1:0] dn, dm;
    always_comb begin
        num = '0; den = '0; ord = ORD_EQ; st = ST_OK;
        dn = '0; dm = '0;
        if (op_reg > 3'(OP_RED)) begin
            st = ST_OK;
        end else if (b_reg == '0 || (op_reg != 3'(OP_RED) && d_reg == '0)) begin
            st = ST_ZERODEN;
        end else begin
            case (op_reg)
                OP_ADD, OP_SUB: begin
                    if (b_reg == d_reg) begin
                        num = (op_reg == 3'(OP_ADD)) ? 64'(a_reg) + 64'(c_reg)
                                                     : 64'(a_reg) - 64'(c_reg);
                        den = 64'(b_reg);
                    end else begin
                        num = (op_reg == 3'(OP_ADD)) ? 64'(p1_reg + p3) : 64'(p1_reg - p3);
                        den = 64'(p2_reg);
                    end
                end
                OP_MUL: begin num = 64'(p1_reg); den = 64'(p2_reg); end
                OP_DIV: begin
                    if (c_reg == '0) begin
                        st = ST_DIVZERO;
                    end else begin
                        dn = p1_reg; dm = p2_reg;
                        if (dm < 0) begin dn = -dn; dm = -dm; end
                        num = 64'(dn); den = 64'(dm);
                    end
                end
                OP_CMP: ord = (p1_reg > p3) ? ORD_FIRST : (p1_reg < p3) ? ORD_SECOND : ORD_EQ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mvalid_reg <= 1'b0;
            gcd_started_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            mvalid_reg <= (state_next == S_OUT);
            gcd_started_reg <= gcd_go;
        end
        if (state_reg == S_IDLE && s_valid) begin
            op_reg <= s_data.opcode;
            a_reg <= (ib < 0) ? W'(-ia) : ia;
            b_reg <= (ib < 0) ? W'(-ib) : ib;
            c_reg <= (id < 0) ? W'(-ic) : ic;
            d_reg <= (id < 0) ? W'(-id) : id;
        end
        if (state_reg == S_M2) p1_reg <= prod;
        if (state_reg == S_M3) p2_reg <= prod;
        if (state_reg == S_FIN) begin
            res_reg <= '{result_numerator: num, result_denominator: den[61:0],
                         order_result: ord, status: st};
        end
        if (state_reg == S_GCD && gcd_done) begin
            res_reg <= '{result_numerator: a_reg[W-1] ? -64'(qx) : 64'(qx),
                         result_denominator: 62'(qy), order_result: ORD_EQ, status: ST_OK};
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT) && mvalid_reg;
    assign m_data  = res_reg;

    property p_ready_idle;
        @(posedge aclk) disable iff (!aresetn) m_valid |-> !s_ready;
    endproperty
    a_ready_idle: assert property (p_ready_idle) else $error("accept during result hold");

    property p_out_hold;
        @(posedge aclk) disable iff (!aresetn) (m_valid && !m_ready) |=> m_valid;
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result dropped");

    property p_gcd_mult;
        @(posedge aclk) disable iff (!aresetn) gcd_started_reg |-> !mul_go;
    endproperty
    a_gcd_mult: assert property (p_gcd_mult) else $error("units overlap");
endmodule
`default_nettype wire

// File: rtl/rfa_mul.sv
`default_nettype none
// Sequential signed multiplier: the product is registered, loaded only while start is high.
module rfa_mul #(
    parameter int W = 33
) (
    input  wire logic                aclk,
    input  wire logic                start,
    input  wire logic signed [W-1:0] op_a,
    input  wire logic signed [W-1:0] op_b,
    output logic signed [2*W-1:0]    prod
);
    logic signed [2*W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            prod_reg <= op_a * op_b;
        end
    end

    assign prod = prod_reg;
endmodule
`default_nettype wire

// File: rtl/rfa_divgcd.sv
`default_nettype none
// Iterative unit: binary gcd of two magnitudes, then restoring division of
// both by the gcd, one quotient bit per cycle, the two quotients side by side.
module rfa_divgcd #(
    parameter int W = 33
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         start,
    input  wire logic [W-1:0] x_in,
    input  wire logic [W-1:0] y_in,
    output logic [W-1:0]      qx,
    output logic [W-1:0]      qy,
    output logic              done
);
    localparam int CW = $clog2(W + 1);

    typedef enum logic [4:0] {
        G_IDLE  = 5'b00001,
        G_TWOS  = 5'b00010,
        G_STEP  = 5'b00100,
        G_DIV   = 5'b01000,
        G_DONE  = 5'b10000
    } gstate_t;

    gstate_t        state_reg, state_next;
    logic [W-1:0]   x_reg, y_reg, ox_reg, oy_reg, g_reg;
    logic [CW-1:0]  sh_reg, cnt_reg;
    logic [W-1:0]   rx_reg, ry_reg, qx_reg, qy_reg;
    logic [W:0]     tx, ty;

    always_comb begin
        tx = {rx_reg, ox_reg[W-1]};
        ty = {ry_reg, oy_reg[W-1]};
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            G_IDLE: if (start) state_next = G_TWOS;
            G_TWOS: if ((x_reg[0] | y_reg[0]) || x_reg == '0 || y_reg == '0)
                state_next = G_STEP;
            G_STEP: if (x_reg == '0 || y_reg == '0) state_next = G_DIV;
            G_DIV:  if (cnt_reg == CW'(W - 1)) state_next = G_DONE;
            G_DONE: state_next = G_IDLE;
            default: state_next = G_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= G_IDLE;
        end else begin
            state_reg <= state_next;
        end
        case (state_reg)
            G_IDLE: begin
                x_reg <= x_in; y_reg <= y_in; ox_reg <= x_in; oy_reg <= y_in;
                sh_reg <= '0;
            end
            G_TWOS: begin
                if (!((x_reg[0] | y_reg[0]) || x_reg == '0 || y_reg == '0)) begin
                    x_reg <= x_reg >> 1; y_reg <= y_reg >> 1; sh_reg <= sh_reg + 1'b1;
                end
            end
            G_STEP: begin
                // one gcd step: strip a factor two or subtract smaller from larger; once either is zero, form the gcd
                if (x_reg == '0 || y_reg == '0) begin
                    g_reg <= (x_reg | y_reg) << sh_reg;
                    cnt_reg <= '0; rx_reg <= '0; ry_reg <= '0;
                end else if (!x_reg[0]) begin
                    x_reg <= x_reg >> 1;
                end else if (!y_reg[0]) begin
                    y_reg <= y_reg >> 1;
                end else if (x_reg > y_reg) begin
                    x_reg <= x_reg - y_reg;
                end else begin
                    y_reg <= y_reg - x_reg;
                end
            end
            G_DIV: begin
                cnt_reg <= cnt_reg + 1'b1;
                ox_reg <= {ox_reg[W-2:0], 1'b0};
                oy_reg <= {oy_reg[W-2:0], 1'b0};
                if (tx >= {1'b0, g_reg}) begin
                    rx_reg <= W'(tx - {1'b0, g_reg}); qx_reg <= {qx_reg[W-2:0], 1'b1};
                end else begin
                    rx_reg <= W'(tx); qx_reg <= {qx_reg[W-2:0], 1'b0};
                end
                if (ty >= {1'b0, g_reg}) begin
                    ry_reg <= W'(ty - {1'b0, g_reg}); qy_reg <= {qy_reg[W-2:0], 1'b1};
                end else begin
                    ry_reg <= W'(ty); qy_reg <= {qy_reg[W-2:0], 1'b0};
                end
            end
            default: ;
        endcase
    end

    assign qx = qx_reg;
    assign qy = qy_reg;
    assign done = (state_reg == G_DONE);
endmodule
`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import rfa_pkg::*;

    localparam int W = 32;
    localparam int TOTAL_RANDOM = 1500;
    localparam int CYCLE_LIMIT = 4000000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    rational_fraction_alu #(.OPERAND_WIDTH(W)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 20 ns clock
    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    in_item_t  pending_ops[$];
    out_item_t expected_fracs[$];
    int        fail_count;
    int        cycle_count;
    int        sent_count;
    int        got_count;
    int        cmp_count;
    int        red_count;
    int        status_count;
    bit        stim_done;
    bit        hold_sender;
    bit        in_taken;
    int        burst_left;
    int        gap_left;
    int        stall_phase;

    function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
        longint unsigned t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // compute the expected result of one fraction transaction
    function automatic out_item_t fraction_result(in_item_t it);
        out_item_t       r;
        longint          a, b, c, d, n, m, l, rr;
        longint unsigned mag, g;
        logic [2:0]      op;
        r = '0;
        op = it.opcode;
        a = longint'(it.first_numerator);
        b = longint'(it.first_denominator);
        c = longint'(it.second_numerator);
        d = longint'(it.second_denominator);
        if (b < 0) begin
            b = -b;
            a = -a;
        end
        if (d < 0) begin
            d = -d;
            c = -c;
        end
        if (op > OP_RED) begin
            return r;
        end
        if (b == 0 || (op != OP_RED && d == 0)) begin
            r.status = ST_ZERODEN;
            return r;
        end
        case (op)
            OP_ADD, OP_SUB: begin
                if (b == d) begin
                    n = (op == OP_ADD) ? a + c : a - c;
                    m = b;
                end else begin
                    n = (op == OP_ADD) ? a * d + c * b : a * d - c * b;
                    m = b * d;
                end
                r.result_numerator = n;
                r.result_denominator = m[61:0];
            end
            OP_MUL: begin
                n = a * c;
                m = b * d;
                r.result_numerator = n;
                r.result_denominator = m[61:0];
            end
            OP_DIV: begin
                if (c == 0) begin
                    r.status = ST_DIVZERO;
                end else begin
                    n = a * d;
                    m = b * c;
                    if (m < 0) begin
                        m = -m;
                        n = -n;
                    end
                    r.result_numerator = n;
                    r.result_denominator = m[61:0];
                end
            end
            OP_CMP: begin
                l = a * d;
                rr = c * b;
                r.order_result = (l > rr) ? ORD_FIRST : (l < rr) ? ORD_SECOND : ORD_EQ;
            end
            default: begin
                mag = (a < 0) ? longint'(-a) : a;
                g = (mag == 0) ? longint'(b) : gcd_of(mag, b);
                n = mag / g;
                r.result_numerator = (a < 0) ? -n : n;
                m = b / longint'(g);
                r.result_denominator = m[61:0];
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on result %0d: %s got %0d expected %0d", got_count, what, got, want);
        fail_count++;
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 32'sd0;
            1: return 32'h7fffffff;
            2: return 32'h80000001;
            3: return 32'h80000000;
            4: return $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
            5, 6: return 32'($signed($urandom_range(0, 40)) - 20);
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_op(logic [2:0] op, logic [31:0] a, logic [31:0] b,
                            logic [31:0] c, logic [31:0] d);
        in_item_t it;
        it.opcode = op;
        it.first_numerator = a;
        it.first_denominator = b;
        it.second_numerator = c;
        it.second_denominator = d;
        pending_ops.push_back(it);
    endtask

    // driver: bursts of transactions separated by random gaps; in_taken marks
    // the transaction accepted at the last rising edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!(s_valid && !in_taken)) begin
            if (in_taken) begin
                void'(pending_ops.pop_front());
                if (burst_left > 0) begin
                    burst_left--;
                end
            end
            if (hold_sender || pending_ops.size() == 0) begin
                s_valid <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (burst_left == 0) begin
                burst_left = $urandom_range(1, 12);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 300);
                s_valid <= (gap_left == 0);
                s_data <= pending_ops[0];
            end else begin
                s_valid <= 1'b1;
                s_data <= pending_ops[0];
            end
        end
    end

    // receiver stall pattern
    always @(negedge aclk) begin
        stall_phase++;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if ((stall_phase / 2000) % 3 == 0) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= (stall_phase % 7 < 3) ? 1'b1 : ($urandom_range(0, 3) == 0);
        end
    end

    // monitor: predict on accept, check each result against the oldest prediction
    always @(posedge aclk) begin
        out_item_t want;
        in_taken = s_valid && s_ready;
        if (aresetn) begin
            cycle_count++;
            if (s_valid && s_ready) begin
                expected_fracs.push_back(fraction_result(s_data));
                sent_count++;
                if (s_data.opcode == OP_CMP) cmp_count++;
                if (s_data.opcode == OP_RED) red_count++;
            end
            if (m_valid && m_ready) begin
                got_count++;
                if (expected_fracs.size() == 0) begin
                    $display("unexpected result with nothing pending");
                    fail_count++;
                end else begin
                    want = expected_fracs.pop_front();
                    if (want.status != 2'(ST_OK)) status_count++;
                    if (m_data.result_numerator !== want.result_numerator)
                        report_mismatch("numerator", m_data.result_numerator,
                                        want.result_numerator);
                    if (m_data.result_denominator !== want.result_denominator)
                        report_mismatch("denominator", m_data.result_denominator,
                                        want.result_denominator);
                    if (m_data.order_result !== want.order_result)
                        report_mismatch("order", m_data.order_result, want.order_result);
                    if (m_data.status !== want.status)
                        report_mismatch("status", m_data.status, want.status);
                end
            end
            if (cycle_count > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycle_count);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [2:0] op;
        int         n;
        fail_count = 0;
        cycle_count = 0;
        sent_count = 0;
        got_count = 0;
        cmp_count = 0;
        red_count = 0;
        status_count = 0;
        stim_done = 0;
        hold_sender = 0;
        in_taken = 0;
        burst_left = 0;
        gap_left = 0;
        stall_phase = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;

        // directed: every opcode, field extremes, zero denominators, divide by zero
        queue_op(OP_ADD, 32'sd1, 32'sd3, 32'sd2, 32'sd3);
        queue_op(OP_ADD, 32'h7fffffff, 32'h80000001, 32'h7fffffff, 32'sd5);
        queue_op(OP_SUB, 32'sd1, -32'sd3, 32'sd2, 32'sd7);
        queue_op(OP_SUB, 32'h80000001, 32'h7fffffff, 32'h7fffffff, 32'h80000001);
        queue_op(OP_MUL, 32'h7fffffff, 32'h7fffffff, 32'h80000001, 32'h7fffffff);
        queue_op(OP_MUL, -32'sd4, -32'sd6, 32'sd3, 32'sd9);
        queue_op(OP_DIV, 32'sd3, 32'sd4, -32'sd5, 32'sd6);
        queue_op(OP_DIV, 32'sd3, 32'sd4, 32'sd0, 32'sd6);
        queue_op(OP_DIV, 32'h7fffffff, 32'sd1, 32'h80000001, 32'h80000001);
        queue_op(OP_CMP, 32'sd1, 32'sd2, 32'sd2, 32'sd4);
        queue_op(OP_CMP, 32'sd1, 32'sd2, 32'sd1, 32'sd3);
        queue_op(OP_CMP, -32'sd1, 32'sd2, 32'sd1, -32'sd3);
        queue_op(OP_RED, 32'sd12, -32'sd18, 32'sd0, 32'sd0);
        queue_op(OP_RED, 32'sd0, 32'sd7, 32'sd1, 32'sd1);
        queue_op(OP_RED, 32'h80000001, 32'h7fffffff, 32'sd0, 32'sd1);
        queue_op(OP_RED, 32'sd64, 32'sd1024, 32'sd0, 32'sd1);
        queue_op(OP_ADD, 32'sd1, 32'sd0, 32'sd1, 32'sd1);
        queue_op(OP_MUL, 32'sd1, 32'sd1, 32'sd1, 32'sd0);
        queue_op(OP_RED, 32'sd5, 32'sd0, 32'sd1, 32'sd0);
        queue_op(3'd6, 32'sd1, 32'sd1, 32'sd1, 32'sd1);
        queue_op(3'd7, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        queue_op(OP_SUB, 32'h80000000, 32'h80000000, 32'h80000000, 32'sd3);
        queue_op(OP_RED, 32'h80000000, 32'sd6, 32'sd0, 32'sd1);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // random: mostly valid opcodes with mixed operands
        for (int i = 0; i < TOTAL_RANDOM; i++) begin
            op = ($urandom_range(0, 29) == 0) ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5));
            queue_op(op, pick_operand(), pick_operand(), pick_operand(), pick_operand());
            if (i == TOTAL_RANDOM / 2) begin
                // drain fully once mid-run
                while (pending_ops.size() > 0) @(posedge aclk);
                hold_sender = 1;
                while (expected_fracs.size() > 0) @(posedge aclk);
                hold_sender = 0;
            end
        end
        while (pending_ops.size() > 0 || expected_fracs.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("sent %0d transactions, %0d results checked (%0d compares, %0d reduces)",
                 sent_count, got_count, cmp_count, red_count);
        $display("%0d results carried an error status", status_count);
        if (fail_count == 0 && expected_fracs.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
rtl/rfa_pkg.sv
rtl/rfa_mul.sv
rtl/rfa_divgcd.sv
rtl/rational_fraction_alu.sv
dv/tb.sv
